[sv/spi_master_byte_transfer_defines.svh]
// Assertion macros for the SPI master byte transfer block.
// Included by the top level; expects clk and rst_n in scope.
`ifndef SPI_MASTER_BYTE_TRANSFER_DEFINES_SVH
`define SPI_MASTER_BYTE_TRANSFER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SPI_MBT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spi_mbt assertion failed");

// Next-cycle implication, disabled in reset.
`define SPI_MBT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spi_mbt assertion failed");

`endif

[sv/spi_mbt_pkg.sv]
// Shared types and constants for the SPI master byte transfer block.
// No dependencies; used by every module of the block.
package spi_mbt_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned BIT_W   = 3;
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [BIT_W-1:0] BIT_LAST = 3'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLARITY    = 4'd0,
    CFG_PHASE       = 4'd1,
    CFG_LSB_FIRST   = 4'd2,
    CFG_FRAME_DLY   = 4'd3,
    CFG_SHIFT_DLY   = 4'd4,
    CFG_DRIVE_DLY   = 4'd5,
    CFG_PRESAMP_DLY = 4'd6,
    CFG_POSTSAMP_DLY = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic              action;
    logic [BYTE_W-1:0] tx_byte;
    logic              miso_level;
  } in_item_t;

  typedef struct packed {
    logic              sck_level;
    logic              mosi_level;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
  } out_item_t;

  typedef struct packed {
    logic              clock_polarity;
    logic              clock_phase;
    logic              lsb_first;
    logic [BYTE_W-1:0] frame_delay;
    logic [BYTE_W-1:0] delay_after_shift_edge;
    logic [BYTE_W-1:0] delay_after_data_drive;
    logic [BYTE_W-1:0] delay_before_sample;
    logic [BYTE_W-1:0] delay_after_sample;
  } cfg_t;

  typedef struct packed {
    logic we;
    logic level;
  } pol_wr_t;

endpackage

[sv/spi_master_byte_transfer.sv]
// SPI master, one byte per transfer, modes 0 to 3, stepped by tick requests.
// Takes one request per clock unless out_ready stalls the result register: a
// request is held in an input register, the sequencer step runs between that
// register and the result register, and back-to-back requests give back-to-back
// results when not stalled. A start request loads the byte; each
// tick request while busy moves the sequencer one step through lead wait, eight bit
// periods and trail wait. cfg_ready is always high; write registers only with
// no requests in flight. Chip select is not generated here.
// Depends on spi_mbt_pkg, spi_mbt_cfg, spi_mbt_core, spi_mbt_oreg.
`include "spi_master_byte_transfer_defines.svh"

module spi_master_byte_transfer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  spi_mbt_pkg::in_item_t              in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output spi_mbt_pkg::out_item_t             out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [spi_mbt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spi_mbt_pkg::BYTE_W-1:0]     cfg_data
);

  logic                   in_valid_r;
  spi_mbt_pkg::in_item_t  in_item_r;
  logic                   oreg_ready;
  logic                   fire;
  spi_mbt_pkg::cfg_t      cfg;
  spi_mbt_pkg::pol_wr_t   pol_wr;
  spi_mbt_pkg::out_item_t core_result;

  assign fire     = in_valid_r && oreg_ready;
  assign in_ready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
  end

  spi_mbt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .pol_wr    (pol_wr)
  );

  spi_mbt_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (fire),
    .item   (in_item_r),
    .cfg    (cfg),
    .pol_wr (pol_wr),
    .result (core_result)
  );

  spi_mbt_oreg u_oreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .load_item  (core_result),
    .load_ready (oreg_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

  `SPI_MBT_ASSERT_NEXT(a_fire_fills_out, fire, out_valid)
  `SPI_MBT_ASSERT_NOW(a_done_not_busy, out_valid && out_item.done_res, !out_item.busy_res)
  `SPI_MBT_ASSERT_NOW(a_rx_zero_unless_done, out_valid && !out_item.done_res,
                      out_item.rx_byte == '0)

endmodule

[sv/spi_mbt_cfg.sv]
// Configuration register file for the SPI master byte transfer block.
// Depends on spi_mbt_pkg.
module spi_mbt_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [spi_mbt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spi_mbt_pkg::BYTE_W-1:0]       cfg_data,
  output spi_mbt_pkg::cfg_t                    cfg,
  output spi_mbt_pkg::pol_wr_t                 pol_wr
);

  spi_mbt_pkg::cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt      = cfg_r;
    pol_wr.we    = 1'b0;
    pol_wr.level = cfg_data[0];
    if (cfg_valid) begin
      unique case (cfg_index)
        spi_mbt_pkg::CFG_POLARITY: begin
          cfg_nxt.clock_polarity = cfg_data[0];
          pol_wr.we = 1'b1;
        end
        spi_mbt_pkg::CFG_PHASE:        cfg_nxt.clock_phase            = cfg_data[0];
        spi_mbt_pkg::CFG_LSB_FIRST:    cfg_nxt.lsb_first              = cfg_data[0];
        spi_mbt_pkg::CFG_FRAME_DLY:    cfg_nxt.frame_delay            = cfg_data;
        spi_mbt_pkg::CFG_SHIFT_DLY:    cfg_nxt.delay_after_shift_edge = cfg_data;
        spi_mbt_pkg::CFG_DRIVE_DLY:    cfg_nxt.delay_after_data_drive = cfg_data;
        spi_mbt_pkg::CFG_PRESAMP_DLY:  cfg_nxt.delay_before_sample    = cfg_data;
        spi_mbt_pkg::CFG_POSTSAMP_DLY: cfg_nxt.delay_after_sample     = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[sv/spi_mbt_core.sv]
// Transfer sequencer: lead wait, eight four-action bit periods, trail wait.
// Advances at most one step per request; depends on spi_mbt_pkg.
module spi_mbt_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  spi_mbt_pkg::in_item_t  item,
  input  spi_mbt_pkg::cfg_t      cfg,
  input  spi_mbt_pkg::pol_wr_t   pol_wr,
  output spi_mbt_pkg::out_item_t result
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_LEAD, PH_S1, PH_S2, PH_S3, PH_S4, PH_TRAIL
  } phase_t;

  typedef enum logic [1:0] {
    OP_EDGE_LEAD, OP_DRIVE, OP_EDGE_TRAIL, OP_SAMPLE
  } op_t;

  phase_t                           phase_r, phase_nxt;
  logic [spi_mbt_pkg::BYTE_W-1:0]   wait_r, wait_nxt;
  logic [spi_mbt_pkg::BIT_W-1:0]    bit_r, bit_nxt;
  logic [spi_mbt_pkg::BYTE_W-1:0]   tx_r, tx_nxt;
  logic [spi_mbt_pkg::BYTE_W-1:0]   rx_r, rx_nxt;
  logic                             sck_r, sck_nxt;
  logic                             mosi_r, mosi_nxt;

  logic                             act;
  logic [1:0]                       act_k;
  op_t                              op;
  logic [spi_mbt_pkg::BIT_W-1:0]    pos;
  logic                             done;

  always_comb begin
    phase_nxt = phase_r;
    wait_nxt  = wait_r;
    bit_nxt   = bit_r;
    tx_nxt    = tx_r;
    rx_nxt    = rx_r;
    sck_nxt   = sck_r;
    mosi_nxt  = mosi_r;
    act       = 1'b0;
    act_k     = 2'd0;
    done      = 1'b0;
    op        = OP_DRIVE;
    pos       = '0;

    if (pol_wr.we && phase_r == PH_IDLE) begin
      sck_nxt = pol_wr.level;
    end

    if (step) begin
      if (!item.action) begin
        if (phase_r == PH_IDLE) begin
          tx_nxt    = item.tx_byte;
          rx_nxt    = '0;
          bit_nxt   = '0;
          sck_nxt   = cfg.clock_polarity;
          wait_nxt  = cfg.frame_delay;
          phase_nxt = PH_LEAD;
        end
      end else if (phase_r != PH_IDLE) begin
        if (wait_r != '0) begin
          wait_nxt = wait_r - 8'd1;
        end else begin
          unique case (phase_r)
            PH_LEAD: act = 1'b1;
            PH_S1: begin
              act   = 1'b1;
              act_k = 2'd1;
            end
            PH_S2: begin
              act   = 1'b1;
              act_k = 2'd2;
            end
            PH_S3: begin
              act   = 1'b1;
              act_k = 2'd3;
            end
            PH_S4: begin
              if (bit_r != spi_mbt_pkg::BIT_LAST) begin
                bit_nxt = bit_r + 3'd1;
                act     = 1'b1;
              end else begin
                phase_nxt = PH_TRAIL;
                wait_nxt  = cfg.frame_delay;
              end
            end
            PH_TRAIL: begin
              phase_nxt = PH_IDLE;
              bit_nxt   = '0;
              done      = 1'b1;
            end
            default: ;
          endcase
        end
      end
    end

    pos = cfg.lsb_first ? bit_nxt : ~bit_nxt;
    if (cfg.clock_phase) begin
      case (act_k)
        2'd0:    op = OP_EDGE_LEAD;
        2'd1:    op = OP_DRIVE;
        2'd2:    op = OP_EDGE_TRAIL;
        default: op = OP_SAMPLE;
      endcase
    end else begin
      case (act_k)
        2'd0:    op = OP_DRIVE;
        2'd1:    op = OP_EDGE_LEAD;
        2'd2:    op = OP_SAMPLE;
        default: op = OP_EDGE_TRAIL;
      endcase
    end

    if (act) begin
      unique case (op)
        OP_EDGE_LEAD: begin
          sck_nxt  = ~cfg.clock_polarity;
          wait_nxt = cfg.clock_phase ? cfg.delay_after_shift_edge : cfg.delay_before_sample;
        end
        OP_DRIVE: begin
          mosi_nxt = tx_r[pos];
          wait_nxt = cfg.delay_after_data_drive;
        end
        OP_EDGE_TRAIL: begin
          sck_nxt  = cfg.clock_polarity;
          wait_nxt = cfg.clock_phase ? cfg.delay_before_sample : cfg.delay_after_shift_edge;
        end
        default: begin
          rx_nxt   = rx_r | (8'(item.miso_level) << pos);
          wait_nxt = cfg.delay_after_sample;
        end
      endcase
      case (act_k)
        2'd0:    phase_nxt = PH_S1;
        2'd1:    phase_nxt = PH_S2;
        2'd2:    phase_nxt = PH_S3;
        default: phase_nxt = PH_S4;
      endcase
    end

    result.sck_level  = sck_nxt;
    result.mosi_level = mosi_nxt;
    result.busy_res   = (phase_nxt != PH_IDLE);
    result.done_res   = done;
    result.rx_byte    = done ? rx_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      wait_r  <= '0;
      bit_r   <= '0;
      tx_r    <= '0;
      rx_r    <= '0;
      sck_r   <= 1'b0;
      mosi_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      wait_r  <= wait_nxt;
      bit_r   <= bit_nxt;
      tx_r    <= tx_nxt;
      rx_r    <= rx_nxt;
      sck_r   <= sck_nxt;
      mosi_r  <= mosi_nxt;
    end
  end

endmodule

[sv/spi_mbt_oreg.sv]
// Result register with valid/ready handshake toward the consumer.
// Depends on spi_mbt_pkg.
module spi_mbt_oreg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  spi_mbt_pkg::out_item_t load_item,
  output logic                   load_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output spi_mbt_pkg::out_item_t out_item
);

  logic                   valid_r;
  spi_mbt_pkg::out_item_t item_r;

  assign load_ready = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ready) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ready) begin
      item_r <= load_item;
    end
  end

endmodule
